// ===== hdl/sle_pkg.sv =====
package sle_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_LAST,
    PTR_POS_M1,
    PTR_POS,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_PUT
  } wr_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_READ,
    RES_FOUND
  } res_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_SRCH_FILL,
    S_SRCH,
    S_INS_FILL,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_FILL,
    S_DEL_SHIFT
  } state_t;

  typedef struct packed {
    logic     load;
    ptr_op_t  ptr_op;
    logic     mem_rd;
    wr_op_t   wr_op;
    logic     finish;
    status_t  status;
    res_sel_t res_sel;
    cnt_op_t  cnt_op;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bad_rd;
    logic  bad_ins;
    logic  full;
    logic  ins_append;
    logic  del_last;
    logic  empty;
    logic  match;
    logic  at_pos_m1;
    logic  at_last;
  } dp_status_t;

endpackage

// ===== hdl/sle_ctrl.sv =====
module sle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sle_pkg::dp_status_t stat,
  output sle_pkg::ctrl_cmd_t  cmd
);

  sle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != sle_pkg::S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.ptr_op  = sle_pkg::PTR_HOLD;
    cmd.wr_op   = sle_pkg::WR_NONE;
    cmd.status  = sle_pkg::ST_OK;
    cmd.res_sel = sle_pkg::RES_NONE;
    cmd.cnt_op  = sle_pkg::CNT_HOLD;
    case (state)
      sle_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sle_pkg::S_DECODE;
        end
      end
      sle_pkg::S_DECODE: begin
        case (stat.mode)
          sle_pkg::MODE_READ: begin
            if (stat.bad_rd) begin
              cmd.finish = 1'b1;
              cmd.status = sle_pkg::ST_RANGE;
              state_next = sle_pkg::S_IDLE;
            end else begin
              cmd.ptr_op = sle_pkg::PTR_POS_M1;
              state_next = sle_pkg::S_RD_WAIT;
            end
          end
          sle_pkg::MODE_SEARCH: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              state_next = sle_pkg::S_IDLE;
            end else begin
              cmd.ptr_op = sle_pkg::PTR_ZERO;
              state_next = sle_pkg::S_SRCH_FILL;
            end
          end
          sle_pkg::MODE_INSERT: begin
            if (stat.bad_ins) begin
              cmd.finish = 1'b1;
              cmd.status = sle_pkg::ST_RANGE;
              state_next = sle_pkg::S_IDLE;
            end else if (stat.full) begin
              cmd.finish = 1'b1;
              cmd.status = sle_pkg::ST_FULL;
              state_next = sle_pkg::S_IDLE;
            end else if (stat.ins_append) begin
              state_next = sle_pkg::S_INS_PUT;
            end else begin
              cmd.ptr_op = sle_pkg::PTR_LAST;
              state_next = sle_pkg::S_INS_FILL;
            end
          end
          default: begin
            if (stat.bad_rd) begin
              cmd.finish = 1'b1;
              cmd.status = sle_pkg::ST_RANGE;
              state_next = sle_pkg::S_IDLE;
            end else if (stat.del_last) begin
              cmd.finish = 1'b1;
              cmd.cnt_op = sle_pkg::CNT_DEC;
              state_next = sle_pkg::S_IDLE;
            end else begin
              cmd.ptr_op = sle_pkg::PTR_POS;
              state_next = sle_pkg::S_DEL_FILL;
            end
          end
        endcase
      end
      sle_pkg::S_RD_WAIT: begin
        // ptr was loaded last cycle; the read lands in rdata at this edge,
        // so the result register samples it in the next cycle
        cmd.mem_rd = 1'b1;
        state_next = sle_pkg::S_SRCH_FILL;
        if (stat.mode == sle_pkg::MODE_READ) begin
          state_next = sle_pkg::S_SRCH;
        end
      end
      sle_pkg::S_SRCH_FILL: begin
        cmd.mem_rd = 1'b1;
        cmd.ptr_op = sle_pkg::PTR_INC;
        state_next = sle_pkg::S_SRCH;
      end
      sle_pkg::S_SRCH: begin
        if (stat.mode == sle_pkg::MODE_READ) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = sle_pkg::RES_READ;
          state_next  = sle_pkg::S_IDLE;
        end else if (stat.match) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = sle_pkg::RES_FOUND;
          state_next  = sle_pkg::S_IDLE;
        end else if (stat.at_last) begin
          cmd.finish = 1'b1;
          state_next = sle_pkg::S_IDLE;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.ptr_op = sle_pkg::PTR_INC;
        end
      end
      sle_pkg::S_INS_FILL: begin
        cmd.mem_rd = 1'b1;
        cmd.ptr_op = sle_pkg::PTR_DEC;
        state_next = sle_pkg::S_INS_SHIFT;
      end
      sle_pkg::S_INS_SHIFT: begin
        cmd.wr_op = sle_pkg::WR_UP;
        if (stat.at_pos_m1) begin
          state_next = sle_pkg::S_INS_PUT;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.ptr_op = sle_pkg::PTR_DEC;
        end
      end
      sle_pkg::S_INS_PUT: begin
        cmd.wr_op  = sle_pkg::WR_PUT;
        cmd.finish = 1'b1;
        cmd.cnt_op = sle_pkg::CNT_INC;
        state_next = sle_pkg::S_IDLE;
      end
      sle_pkg::S_DEL_FILL: begin
        cmd.mem_rd = 1'b1;
        cmd.ptr_op = sle_pkg::PTR_INC;
        state_next = sle_pkg::S_DEL_SHIFT;
      end
      sle_pkg::S_DEL_SHIFT: begin
        cmd.wr_op = sle_pkg::WR_DOWN;
        if (stat.at_last) begin
          cmd.finish = 1'b1;
          cmd.cnt_op = sle_pkg::CNT_DEC;
          state_next = sle_pkg::S_IDLE;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.ptr_op = sle_pkg::PTR_INC;
        end
      end
      default: begin
        state_next = sle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/sle_datapath.sv =====
module sle_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sle_pkg::ctrl_cmd_t  cmd,
  output sle_pkg::dp_status_t stat,
  input  logic [1:0]          mode,
  input  logic [7:0]          position,
  input  logic signed [31:0]  value,
  output logic                done,
  output logic [1:0]          status,
  output logic signed [31:0]  read_value,
  output logic [7:0]          found_position,
  output logic [7:0]          list_length
);

  localparam int IW = sle_pkg::IDX_W;
  localparam int CW = sle_pkg::CNT_W;
  localparam int MW = sle_pkg::CMP_W;

  logic [31:0]   mem [sle_pkg::CAPACITY];
  logic [31:0]   rdata;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] ptr;
  logic [CW-1:0] count, count_next;

  sle_pkg::mode_t mode_q;
  logic [7:0]     pos_q;
  logic [31:0]    val_q;

  logic [MW-1:0] pos_x, n_x, pos_m1_x, n_m1_x;
  logic [IW-1:0] pos_m1_i, n_m1_i, wr_addr;
  logic [31:0]   wr_data;

  always_comb begin
    pos_x    = MW'(pos_q);
    n_x      = MW'(count);
    pos_m1_x = pos_x - MW'(1);
    n_m1_x   = n_x - MW'(1);
    pos_m1_i = pos_m1_x[IW-1:0];
    n_m1_i   = n_m1_x[IW-1:0];
  end

  always_comb begin
    stat.mode       = mode_q;
    stat.bad_rd     = (pos_q == 8'd0) || (pos_x > n_x);
    stat.bad_ins    = (pos_q == 8'd0) || (pos_x > n_x + MW'(1));
    stat.full       = (n_x >= MW'(sle_pkg::CAPACITY));
    stat.ins_append = (pos_m1_x == n_x);
    stat.del_last   = (pos_x == n_x);
    stat.empty      = (count == '0);
    stat.match      = (rdata == val_q);
    stat.at_pos_m1  = (rd_idx == pos_m1_i);
    stat.at_last    = (rd_idx == n_m1_i);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= sle_pkg::mode_t'(mode);
      pos_q  <= position;
      val_q  <= value;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.ptr_op)
      sle_pkg::PTR_ZERO:   ptr <= '0;
      sle_pkg::PTR_LAST:   ptr <= n_m1_i;
      sle_pkg::PTR_POS_M1: ptr <= pos_m1_i;
      sle_pkg::PTR_POS:    ptr <= pos_x[IW-1:0];
      sle_pkg::PTR_INC:    ptr <= ptr + IW'(1);
      sle_pkg::PTR_DEC:    ptr <= ptr - IW'(1);
      default:             ptr <= ptr;
    endcase
  end

  // shifts move one word per cycle: the word read last cycle is written
  // one slot up (insert) or down (delete) while the next one is read
  always_comb begin
    case (cmd.wr_op)
      sle_pkg::WR_UP: begin
        wr_addr = rd_idx + IW'(1);
        wr_data = rdata;
      end
      sle_pkg::WR_DOWN: begin
        wr_addr = rd_idx - IW'(1);
        wr_data = rdata;
      end
      default: begin
        wr_addr = pos_m1_i;
        wr_data = val_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op != sle_pkg::WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rdata  <= mem[ptr];
      rd_idx <= ptr;
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      sle_pkg::CNT_INC: count_next = count + CW'(1);
      sle_pkg::CNT_DEC: count_next = count - CW'(1);
      default:          count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= cmd.status;
      list_length <= 8'(count_next);
      read_value  <= (cmd.res_sel == sle_pkg::RES_READ) ? rdata : '0;
      found_position <= (cmd.res_sel == sle_pkg::RES_FOUND) ?
                        8'({1'b0, rd_idx} + (IW + 1)'(1)) : 8'd0;
    end
  end

endmodule

// ===== hdl/sequential_list_engine.sv =====
// channel   ports                                          handshake
// --------  ---------------------------------------------  --------------------------
// command   mode, position, value                          start & !busy
// result    status, read_value, found_position, list_length  done (one cycle)
//
// One word in flight at a time; the list lives in a 128-entry single-read RAM.
// A read fetches the word at position; a search walks up from the first word
// to a match or the last word; an insert moves the words from position on one
// slot up, one word per cycle, then writes the value (an append writes at once);
// a delete moves the words above position one slot down, one word per cycle.
// Range and full errors, empty searches and last-word deletes finish at decode.
// Reset clears the length, not the RAM, and no word is read before it is written.
// done is a single-cycle strobe the receiver cannot hold off; busy drops in the
// same cycle so a new start can be taken while the result is shown.
module sequential_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [7:0]         found_position,
  output logic [7:0]         list_length
);

  sle_pkg::ctrl_cmd_t  cmd;
  sle_pkg::dp_status_t stat;

  sle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sle_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (mode),
    .position       (position),
    .value          (value),
    .done           (done),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .list_length    (list_length)
  );

endmodule

// ===== tb/sequential_list_engine_test.sv =====
module sequential_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    status_t     status;
    logic [31:0] rd;
    logic [7:0]  found;
    logic [7:0]  len;
  } list_result_t;

  typedef struct packed {
    mode_t        mode;
    logic [7:0]   pos;
    logic [31:0]  val;
    logic         typed;
    list_result_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode = MODE_READ;
  logic [7:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         found_position;
  logic [7:0]         list_length;

  // shadow copy of the list, updated in acceptance order
  logic [31:0]  list_model [CAPACITY];
  int           model_len = 0;
  list_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  int           err_count = 0;
  int           cycle_count = 0;
  int           idle_pct = 0;

  sequential_list_engine u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .position       (position),
    .value          (value),
    .done           (done),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .list_length    (list_length)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  function automatic list_result_t mk_res(input status_t s, input logic [31:0] rd,
                                          input int found, input int len);
    list_result_t r;
    r.status = s;
    r.rd     = rd;
    r.found  = 8'(found);
    r.len    = 8'(len);
    return r;
  endfunction

  function automatic list_result_t predict_list_op(input mode_t m, input logic [7:0] p,
                                                   input logic [31:0] v);
    list_result_t r;
    int j;
    int pi;
    pi = int'(p);
    r.status = ST_OK;
    r.rd     = '0;
    r.found  = '0;
    case (m)
      MODE_READ: begin
        if (pi < 1 || pi > model_len) r.status = ST_RANGE;
        else r.rd = list_model[pi - 1];
      end
      MODE_SEARCH: begin
        for (j = 0; j < model_len; j++)
          if (r.found == 0 && list_model[j] == v) r.found = 8'(j + 1);
      end
      MODE_INSERT: begin
        // position is checked before fullness
        if (pi < 1 || pi > model_len + 1) r.status = ST_RANGE;
        else if (model_len >= CAPACITY) r.status = ST_FULL;
        else begin
          for (j = model_len; j > pi - 1; j--) list_model[j] = list_model[j - 1];
          list_model[pi - 1] = v;
          model_len++;
        end
      end
      default: begin
        if (pi < 1 || pi > model_len) r.status = ST_RANGE;
        else begin
          for (j = pi; j < model_len; j++) list_model[j - 1] = list_model[j];
          model_len--;
        end
      end
    endcase
    r.len = 8'(model_len);
    return r;
  endfunction

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(input mode_t m, input logic [7:0] p, input logic [31:0] v,
                           input logic typed, input list_result_t typed_res);
    list_result_t want;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    mode     <= m;
    position <= p;
    value    <= v;
    do @(posedge clk); while (!(start && !busy));
    want = predict_list_op(m, p, v);
    pending_results.push_back(typed ? typed_res : want);
  endtask

  task automatic add_row(input mode_t m, input int p, input logic [31:0] v,
                         input logic typed, input list_result_t want);
    dir_row_t row;
    row.mode  = m;
    row.pos   = 8'(p);
    row.val   = v;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // small values repeat often so searches see duplicates
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return 32'($urandom_range(7));
      1: begin
        case ($urandom_range(2))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // length drifts toward target; a few positions are out of range
  task automatic run_random(input int count, input int target);
    int          k;
    int          r;
    mode_t       op;
    logic [7:0]  p;
    logic [31:0] v;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 15) op = MODE_READ;
      else if (r < 30) op = MODE_SEARCH;
      else if ((model_len < target) ? (r < 88) : (r < 42)) op = MODE_INSERT;
      else op = MODE_DELETE;
      if ($urandom_range(99) < 12) p = 8'($urandom_range(255));
      else if (op == MODE_INSERT) p = 8'($urandom_range(model_len + 1, 1));
      else if (model_len > 0) p = 8'($urandom_range(model_len, 1));
      else p = 8'($urandom_range(255));
      if (op == MODE_SEARCH && model_len > 0 && $urandom_range(1) == 1)
        v = list_model[$urandom_range(model_len - 1)];
      else
        v = pick_value();
      send_word(op, p, v, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", {30'd0, status}, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", {30'd0, status}, {30'd0, want.status});
        if (read_value !== want.rd) report_mismatch("read_value", read_value, want.rd);
        if (found_position !== want.found)
          report_mismatch("found_position", {24'd0, found_position}, {24'd0, want.found});
        if (list_length !== want.len)
          report_mismatch("list_length", {24'd0, list_length}, {24'd0, want.len});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sequential_list_engine test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    int idle_sched [4];
    int target_sched [4];
    idle_sched   = '{0, 81, 23, 0};
    target_sched = '{0, 128, 4, 64};

    // empty list
    add_row(MODE_READ,   1, 32'd0, 1'b1, mk_res(ST_RANGE, 0, 0, 0));
    add_row(MODE_DELETE, 1, 32'd0, 1'b1, mk_res(ST_RANGE, 0, 0, 0));
    add_row(MODE_SEARCH, 0, 32'd0, 1'b1, mk_res(ST_OK, 0, 0, 0));
    add_row(MODE_INSERT, 0, 32'd5, 1'b1, mk_res(ST_RANGE, 0, 0, 0));
    add_row(MODE_INSERT, 2, 32'd5, 1'b1, mk_res(ST_RANGE, 0, 0, 0));
    add_row(MODE_INSERT, 1, 32'h7fff_ffff, 1'b1, mk_res(ST_OK, 0, 0, 1));
    add_row(MODE_INSERT, 1, 32'h8000_0000, 1'b1, mk_res(ST_OK, 0, 0, 2));
    // append, reads at the ends and past them
    add_row(MODE_INSERT, 3, 32'hffff_ffff, 1'b0, '0);
    add_row(MODE_READ,   1, 32'd0, 1'b0, '0);
    add_row(MODE_READ,   3, 32'd0, 1'b0, '0);
    add_row(MODE_READ,   4, 32'd0, 1'b0, '0);
    add_row(MODE_READ,   0, 32'd0, 1'b1, mk_res(ST_RANGE, 0, 0, 3));
    // search ignores position
    add_row(MODE_SEARCH, 255, 32'h7fff_ffff, 1'b0, '0);
    add_row(MODE_SEARCH, 0, 32'hffff_ffff, 1'b0, '0);
    add_row(MODE_SEARCH, 7, 32'd5, 1'b0, '0);
    add_row(MODE_INSERT, 2, 32'd0, 1'b0, '0);
    add_row(MODE_INSERT, 4, 32'hffff_ffff, 1'b0, '0);
    add_row(MODE_SEARCH, 0, 32'hffff_ffff, 1'b0, '0);
    add_row(MODE_DELETE, 255, 32'd0, 1'b0, '0);
    add_row(MODE_DELETE, 6, 32'd0, 1'b0, '0);
    add_row(MODE_DELETE, 5, 32'd0, 1'b0, '0);
    add_row(MODE_DELETE, 1, 32'd0, 1'b0, '0);
    add_row(MODE_READ,   255, 32'd0, 1'b0, '0);
    add_row(MODE_INSERT, 255, 32'hdead_beef, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 23;
    foreach (dir_rows[k])
      send_word(dir_rows[k].mode, dir_rows[k].pos, dir_rows[k].val,
                dir_rows[k].typed, dir_rows[k].want);

    // fill to capacity, then the full-list cases
    idle_pct = 0;
    while (model_len < CAPACITY)
      send_word(MODE_INSERT, 8'($urandom_range(model_len + 1, 1)), pick_value(), 1'b0, '0);
    idle_pct = 81;
    send_word(MODE_INSERT, 8'd1, 32'd1, 1'b1, mk_res(ST_FULL, 0, 0, CAPACITY));
    send_word(MODE_INSERT, 8'(CAPACITY + 1), 32'd1, 1'b1, mk_res(ST_FULL, 0, 0, CAPACITY));
    send_word(MODE_INSERT, 8'(CAPACITY + 2), 32'd1, 1'b1, mk_res(ST_RANGE, 0, 0, CAPACITY));
    send_word(MODE_SEARCH, 8'd0, 32'h1234_5679, 1'b0, '0);
    send_word(MODE_SEARCH, 8'd0, list_model[CAPACITY - 1], 1'b0, '0);
    send_word(MODE_READ, 8'(CAPACITY), 32'd0, 1'b0, '0);
    send_word(MODE_DELETE, 8'd1, 32'd0, 1'b0, '0);
    send_word(MODE_INSERT, 8'd1, 32'h8000_0000, 1'b0, '0);

    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_sched[ph];
      run_random(60, target_sched[ph]);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("sequential_list_engine test passed");
    end else begin
      $display("sequential_list_engine test failed");
    end
    $finish;
  end

endmodule
